// ===== sv/adpcm_ssd_pkg.sv =====
// Shared types, constants and functions for the split stereo ADPCM decoder.
// Used by adpcm_ssd_mac and adpcm_stereo_split_decoder_unit; depends on nothing.

package adpcm_ssd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 10;
    localparam int PROD_W          = SAMPLE_W + COEF_W;
    localparam int ACC_W           = 28;
    localparam int POS_W           = 7;
    localparam int STEP_W          = 3;
    localparam int BLOCK_BYTES_DEF = 14;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32'h80);
    localparam logic [4:0]              SHIFT_BASE = 5'd8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;     // update the accumulator this cycle
        logic load;   // start a new sum from the addend
    } ssd_mac_ctl_t;

    // Predictor coefficient table; pair is (idx, idx + 4)
    function automatic logic signed [COEF_W-1:0] coef(logic [4:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            5'd1:    c = 10'sd240;
            5'd2:    c = 10'sd460;
            5'd3:    c = 10'sd392;
            5'd6:    c = -10'sd208;
            5'd7:    c = -10'sd220;
            5'd9:    c = 10'sd1;
            5'd10:   c = 10'sd3;
            5'd11:   c = 10'sd4;
            5'd12:   c = 10'sd7;
            5'd13:   c = 10'sd8;
            5'd14:   c = 10'sd10;
            5'd15:   c = 10'sd11;
            5'd17:   c = -10'sd1;
            5'd18:   c = -10'sd3;
            5'd19:   c = -10'sd4;
            default: c = 10'sd0;
        endcase
        return c;
    endfunction

    // Place the nibble at the top of a 32-bit word and shift it down
    function automatic logic signed [ACC_W-1:0] residue(logic [3:0] nib,
                                                        logic [3:0] shift_nib);
        logic signed [31:0] placed;
        logic [4:0]         amt;
        amt    = {1'b0, shift_nib} + SHIFT_BASE;
        placed = $signed({nib, 28'd0}) >>> amt;
        return placed[ACC_W-1:0];
    endfunction

endpackage

// ===== sv/adpcm_ssd_mac.sv =====
// Shared multiply-accumulate unit with output scaling and 16-bit clipping.
// Depends on adpcm_ssd_pkg.

module adpcm_ssd_mac (
    input  logic                                      clk,
    input  adpcm_ssd_pkg::ssd_mac_ctl_t               ctl,
    input  logic signed [adpcm_ssd_pkg::ACC_W-1:0]    addend,
    input  logic signed [adpcm_ssd_pkg::SAMPLE_W-1:0] mul_a,
    input  logic signed [adpcm_ssd_pkg::COEF_W-1:0]   mul_b,
    output logic signed [adpcm_ssd_pkg::SAMPLE_W-1:0] sample
);

    localparam int SCALED_W = adpcm_ssd_pkg::ACC_W - 8;

    logic signed [adpcm_ssd_pkg::PROD_W-1:0] prod;
    logic signed [adpcm_ssd_pkg::ACC_W-1:0]  prod_ext;
    logic signed [adpcm_ssd_pkg::ACC_W-1:0]  sum;
    logic signed [adpcm_ssd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [SCALED_W-1:0]              scaled;

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(adpcm_ssd_pkg::ACC_W - adpcm_ssd_pkg::PROD_W){prod[adpcm_ssd_pkg::PROD_W-1]}},
                       prod};
    assign sum      = (ctl.load ? addend : acc_reg) + prod_ext;
    assign scaled   = sum[adpcm_ssd_pkg::ACC_W-1:8];

    always_comb
    begin
        if (scaled > SCALED_W'(32767))
            sample = 16'sh7FFF;
        else if (scaled < -SCALED_W'(32768))
            sample = 16'sh8000;
        else
            sample = scaled[adpcm_ssd_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            acc_reg <= sum;
    end

endmodule

// ===== sv/adpcm_stereo_split_decoder_unit.sv =====
// Top level of the split stereo ADPCM decoder: sequencer, history and header state.
// Depends on adpcm_ssd_pkg and adpcm_ssd_mac.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready    | command, left_byte, right_byte, 4 history
//  out     | output    | out_valid / out_ready  | left_sample, right_sample, last
//
// A start or header item completes in its transfer. A data item is latched in its transfer
// cycle, then decoded in 8 sequencer steps for four predictions (left high, right high, left low,
// right low), each two passes through the single shared multiply-accumulate unit
// (newest*c1, then older*c2). The input is not ready while a data item is decoded.
// Reset (rst_n, asynchronous, active low) clears history, header nibbles and
// block position; the next data item after reset is a header.
// A frame waiting in the output register stalls the sequencer on the pass that
// would overwrite it; the next input item is taken while the second frame waits.

module adpcm_stereo_split_decoder_unit #(
    parameter int BLOCK_BYTES = adpcm_ssd_pkg::BLOCK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  left_byte,
    input  logic [7:0]  right_byte,
    input  logic signed [15:0] left_hist_cur,
    input  logic signed [15:0] left_hist_prev,
    input  logic signed [15:0] right_hist_cur,
    input  logic signed [15:0] right_hist_prev,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    output logic        last
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    localparam logic [adpcm_ssd_pkg::POS_W-1:0] POS_LAST = adpcm_ssd_pkg::POS_W'(BLOCK_BYTES);
    localparam logic [adpcm_ssd_pkg::POS_W-1:0] POS_ONE  = adpcm_ssd_pkg::POS_W'(1);

    state_t                              state_reg;
    logic [adpcm_ssd_pkg::STEP_W-1:0]    step_reg;
    logic [adpcm_ssd_pkg::POS_W-1:0]     pos_reg;
    logic                                out_valid_reg;

    logic signed [15:0] newest_reg [2];
    logic signed [15:0] older_reg  [2];
    logic [3:0]         coef_idx_reg [2];
    logic [3:0]         shift_reg    [2];

    logic [7:0]         byte_reg [2];
    logic signed [15:0] left_hold_reg;
    logic signed [15:0] out_left_reg;
    logic signed [15:0] out_right_reg;
    logic               out_last_reg;

    logic                                     in_xfer;
    logic                                     out_free;
    logic                                     phase_b;
    logic                                     chan;
    logic                                     low_half;
    logic                                     frame_done;
    logic                                     hold;
    logic                                     advance;
    logic [3:0]                               nib;
    logic [4:0]                               cidx;
    adpcm_ssd_pkg::ssd_mac_ctl_t              mac_ctl;
    logic signed [adpcm_ssd_pkg::ACC_W-1:0]   mac_addend;
    logic signed [15:0]                       mac_a;
    logic signed [adpcm_ssd_pkg::COEF_W-1:0]  mac_b;
    logic signed [15:0]                       sample;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Step decode: bit 0 pass, bit 1 channel, bit 2 low nibble
    assign phase_b    = step_reg[0];
    assign chan       = step_reg[1];
    assign low_half   = step_reg[2];
    assign frame_done = phase_b && chan;          // right channel finished: frame complete
    assign hold       = frame_done && !out_free;  // hold until the output register frees
    assign advance    = (state_reg == ST_RUN) && !hold;

    assign nib  = low_half ? byte_reg[chan][3:0] : byte_reg[chan][7:4];
    assign cidx = {1'b0, coef_idx_reg[chan]} + (phase_b ? 5'd4 : 5'd0);

    assign mac_ctl.en   = advance;
    assign mac_ctl.load = !phase_b;
    assign mac_addend   = adpcm_ssd_pkg::residue(nib, shift_reg[chan])
                          + adpcm_ssd_pkg::ROUND_BIAS;
    assign mac_a        = phase_b ? older_reg[chan] : newest_reg[chan];
    assign mac_b        = adpcm_ssd_pkg::coef(cidx);

    adpcm_ssd_mac u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .addend (mac_addend),
        .mul_a  (mac_a),
        .mul_b  (mac_b),
        .sample (sample)
    );

    // Sequencer, history and header state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            newest_reg[0]   <= '0;
            newest_reg[1]   <= '0;
            older_reg[0]    <= '0;
            older_reg[1]    <= '0;
            coef_idx_reg[0] <= '0;
            coef_idx_reg[1] <= '0;
            shift_reg[0]    <= '0;
            shift_reg[1]    <= '0;
        end
        else
        begin
            // Raise on a finished frame, drop once the waiting frame transfers
            if (advance && frame_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (command == adpcm_ssd_pkg::CMD_START)
                        begin
                            // Load history and expect a header next
                            newest_reg[0] <= left_hist_cur;
                            older_reg[0]  <= left_hist_prev;
                            newest_reg[1] <= right_hist_cur;
                            older_reg[1]  <= right_hist_prev;
                            pos_reg       <= '0;
                        end
                        else if (pos_reg == '0)
                        begin
                            coef_idx_reg[0] <= left_byte[7:4];
                            shift_reg[0]    <= left_byte[3:0];
                            coef_idx_reg[1] <= right_byte[7:4];
                            shift_reg[1]    <= right_byte[3:0];
                            pos_reg         <= POS_ONE;
                        end
                        else
                        begin
                            // Drop back to header once the block is full
                            pos_reg   <= (pos_reg >= POS_LAST) ? '0 : pos_reg + POS_ONE;
                            step_reg  <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (advance)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (phase_b)
                        begin
                            older_reg[chan]  <= newest_reg[chan];
                            newest_reg[chan] <= sample;
                        end
                        if (frame_done && low_half)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Byte latch, left sample hold and output frame register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg[0] <= left_byte;
            byte_reg[1] <= right_byte;
        end
        if (advance && phase_b && !chan)
            left_hold_reg <= sample;
        if (advance && frame_done)
        begin
            out_left_reg  <= left_hold_reg;
            out_right_reg <= sample;
            out_last_reg  <= low_half;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = out_left_reg;
    assign right_sample = out_right_reg;
    assign last         = out_last_reg;

    // A pending second frame keeps the next byte pair from passing its first frame
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && state_reg == ST_RUN) |-> !step_reg[2])
        else $error("byte pair decode ran past a pending second frame");

    // Every decode run starts and ends on step zero
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("sequencer step not zero while idle");

    // Block position never passes the block length
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("block position beyond block length");

    // A frame held back by the output side keeps the history untouched
    a_hold_hist: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && hold) |=> $stable(newest_reg[1]))
        else $error("history changed while the output stalled");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for adpcm_stereo_split_decoder_unit: directed and random streams.
// Depends on adpcm_ssd_pkg and the decoder RTL; predicts every stereo frame in its own model.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_BYTES = adpcm_ssd_pkg::BLOCK_BYTES_DEF;
    localparam int ITEM_TARGET = 720;
    localparam int TAIL_CYCLES = 32;       // slack for the block to settle
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    // One input transfer, plus the sender's idle gap ahead of it
    typedef struct {
        logic               command;
        logic [7:0]         left_byte;
        logic [7:0]         right_byte;
        logic signed [15:0] left_hist_cur;
        logic signed [15:0] left_hist_prev;
        logic signed [15:0] right_hist_cur;
        logic signed [15:0] right_hist_prev;
        int                 gap;
        bit                 drain;         // hold until every frame in flight has come out
    } coded_item_t;

    // One stereo output frame
    typedef struct {
        logic signed [15:0] left_s;
        logic signed [15:0] right_s;
        logic               last_f;
    } frame_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               command = adpcm_ssd_pkg::CMD_START;
    logic [7:0]         left_byte = 8'd0;
    logic [7:0]         right_byte = 8'd0;
    logic signed [15:0] left_hist_cur = 16'sd0;
    logic signed [15:0] left_hist_prev = 16'sd0;
    logic signed [15:0] right_hist_cur = 16'sd0;
    logic signed [15:0] right_hist_prev = 16'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last;

    adpcm_stereo_split_decoder_unit #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .left_byte(left_byte),
        .right_byte(right_byte),
        .left_hist_cur(left_hist_cur),
        .left_hist_prev(left_hist_prev),
        .right_hist_cur(right_hist_cur),
        .right_hist_prev(right_hist_prev),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_sample(left_sample),
        .right_sample(right_sample),
        .last(last)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model: per-channel history and header nibbles
    // (index 0 is left, 1 is right), plus the shared block position.
    // ------------------------------------------------------------------
    int                 coef_rom [20] = '{0, 240, 460, 392, 0, 0, -208, -220,
                                          0, 1, 3, 4, 7, 8, 10, 11, 0, -1, -3, -4};
    logic signed [15:0] hist_new [2] = '{16'sd0, 16'sd0};
    logic signed [15:0] hist_old [2] = '{16'sd0, 16'sd0};
    logic [3:0]         coef_sel [2] = '{4'd0, 4'd0};
    logic [3:0]         shift_sel [2] = '{4'd0, 4'd0};
    int                 blk_pos = 0;

    coded_item_t pending_items [$];
    frame_t      expected_frames [$];

    int mismatch_cnt = 0;
    int accepted_cnt = 0;
    int total_items  = -1;
    int cycle_cnt    = 0;

    // One prediction step for a channel; advance its history
    function automatic logic signed [15:0] predict_sample(int ch, logic [3:0] nib);
        longint             resid;
        longint             acc;
        logic signed [15:0] s;
        resid = nib[3] ? longint'(nib) - 16 : longint'(nib);
        resid = (resid <<< 28) >>> (int'(shift_sel[ch]) + 8);
        acc   = resid + longint'(hist_new[ch]) * longint'(coef_rom[int'(coef_sel[ch])])
                      + longint'(hist_old[ch]) * longint'(coef_rom[int'(coef_sel[ch]) + 4])
                      + 64'sh80;
        acc   = acc >>> 8;
        if (acc > 32767)
            s = 16'sh7FFF;
        else if (acc < -32768)
            s = 16'sh8000;
        else
            s = 16'(acc);
        hist_old[ch] = hist_new[ch];
        hist_new[ch] = s;
        return s;
    endfunction

    // Apply one accepted transfer to the model; queue the frames it yields
    task automatic decode_item(input coded_item_t it);
        frame_t hi_frame;
        frame_t lo_frame;
        if (it.command == adpcm_ssd_pkg::CMD_START) begin
            hist_new[0] = it.left_hist_cur;
            hist_old[0] = it.left_hist_prev;
            hist_new[1] = it.right_hist_cur;
            hist_old[1] = it.right_hist_prev;
            blk_pos     = 0;
        end else if (blk_pos == 0) begin
            // block header: coefficient pair select and shift per channel
            coef_sel[0]  = it.left_byte[7:4];
            shift_sel[0] = it.left_byte[3:0];
            coef_sel[1]  = it.right_byte[7:4];
            shift_sel[1] = it.right_byte[3:0];
            blk_pos      = 1;
        end else begin
            hi_frame.left_s  = predict_sample(0, it.left_byte[7:4]);
            lo_frame.left_s  = predict_sample(0, it.left_byte[3:0]);
            hi_frame.right_s = predict_sample(1, it.right_byte[7:4]);
            lo_frame.right_s = predict_sample(1, it.right_byte[3:0]);
            hi_frame.last_f  = 1'b0;
            lo_frame.last_f  = 1'b1;
            expected_frames.insert(expected_frames.size(), hi_frame);
            expected_frames.insert(expected_frames.size(), lo_frame);
            blk_pos = (blk_pos >= BLOCK_BYTES) ? 0 : blk_pos + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: take the next item from pending_items, wait out its
    // gap (and, for a drain item, until every frame has come out), then
    // present it and hold it until the transfer.
    // ------------------------------------------------------------------
    coded_item_t in_flight;
    coded_item_t next_item;
    bit          staged   = 1'b0;
    int          gap_left = 0;
    bit          launch;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                decode_item(in_flight);
                accepted_cnt++;
            end
            // payload may change only once the current item has transferred
            if (!in_valid || in_ready) begin
                launch = 1'b0;
                if (!staged && pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    staged    = 1'b1;
                    gap_left  = next_item.gap;
                end
                if (staged && gap_left > 0)
                    gap_left--;
                else if (staged && !(next_item.drain && expected_frames.size() != 0))
                    launch = 1'b1;
                if (launch) begin
                    in_flight       = next_item;
                    staged          = 1'b0;
                    command         <= next_item.command;
                    left_byte       <= next_item.left_byte;
                    right_byte      <= next_item.right_byte;
                    left_hist_cur   <= next_item.left_hist_cur;
                    left_hist_prev  <= next_item.left_hist_prev;
                    right_hist_cur  <= next_item.right_hist_cur;
                    right_hist_prev <= next_item.right_hist_prev;
                end
                in_valid <= launch;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each frame transfer against the oldest
    // prediction, then pick a random stall, possibly none, before taking the next one.
    // Every fourth window of the cycle counter (cycle_cnt >> 8) runs with no stalls at all.
    // ------------------------------------------------------------------
    frame_t want;
    int     stall_left = 0;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame L=%0d R=%0d last=%0b",
                                              left_sample, right_sample, last));
                end else begin
                    want = expected_frames.pop_front();
                    if (left_sample !== want.left_s)
                        report_mismatch($sformatf("left_sample %0d, want %0d",
                                                  left_sample, want.left_s));
                    if (right_sample !== want.right_s)
                        report_mismatch($sformatf("right_sample %0d, want %0d",
                                                  right_sample, want.right_s));
                    if (last !== want.last_f)
                        report_mismatch($sformatf("last %0b, want %0b", last, want.last_f));
                end
                stall_left = (((cycle_cnt >> 8) % 4) == 1) ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build-up
    // ------------------------------------------------------------------
    bit         burst_mode = 1'b0;   // no sender gaps for the current sequence
    bit         drain_next = 1'b0;   // next queued item waits for an empty pipe
    logic [7:0] byte_pat [14] = '{8'h00, 8'hFF, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'h88,
                                  8'h77, 8'h01, 8'h10, 8'hE9, 8'h9E, 8'h5A, 8'hA5};

    task automatic push_item(input logic cmd, input logic [7:0] lb, input logic [7:0] rb,
                             input logic signed [15:0] lc, input logic signed [15:0] lp,
                             input logic signed [15:0] rc, input logic signed [15:0] rp);
        coded_item_t it;
        it.command         = cmd;
        it.left_byte       = lb;
        it.right_byte      = rb;
        it.left_hist_cur   = lc;
        it.left_hist_prev  = lp;
        it.right_hist_cur  = rc;
        it.right_hist_prev = rp;
        it.gap             = burst_mode ? 0 : $urandom_range(0, 7);
        it.drain           = drain_next;
        drain_next         = 1'b0;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Start item; the byte fields carry noise the block must ignore
    task automatic push_start(input logic signed [15:0] lc, input logic signed [15:0] lp,
                              input logic signed [15:0] rc, input logic signed [15:0] rp);
        push_item(adpcm_ssd_pkg::CMD_START, 8'($urandom), 8'($urandom), lc, lp, rc, rp);
    endtask

    // Data item (header or residues); history fields carry noise
    task automatic push_data(input logic [7:0] lb, input logic [7:0] rb);
        push_item(adpcm_ssd_pkg::CMD_DATA, lb, rb, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // History value biased toward the clipping corners
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 63)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int n_data;
        int pick;

        // Data before any start decodes against the zero history from reset
        push_data(8'h1F, 8'hF0);
        push_data(8'h80, 8'h7F);

        // Extreme history with steep coefficients, then a short block
        push_start(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_data(8'h2F, 8'h60);
        push_data(8'h77, 8'h88);

        // Full block, so the block end turns the next item into a header
        push_start(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        push_data(8'h30, 8'hCF);
        for (int i = 0; i < BLOCK_BYTES; i++)
            push_data(byte_pat[i % 14], byte_pat[13 - (i % 14)]);
        // header with coefficient index in the upper shared-table range
        push_data(8'hE8, 8'h4A);
        push_data(8'h9F, 8'hF9);

        // Random part: mostly well-formed start/header/data sequences,
        // some runs across the block end, some loose noise items.
        drain_next = 1'b1;
        while (pending_items.size() < ITEM_TARGET) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0)
                drain_next = 1'b1;
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                push_item(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                push_start(pick_sample(), pick_sample(), pick_sample(), pick_sample());
                push_data(8'($urandom), 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    n_data = BLOCK_BYTES + $urandom_range(1, 16);
                else
                    n_data = $urandom_range(1, BLOCK_BYTES);
                for (int i = 0; i < n_data; i++)
                    push_data(8'($urandom), 8'($urandom));
            end
        end
        total_items = pending_items.size();

        // Hold reset low from the start, then release it at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transfer in, every frame out, then let the block settle
        while (accepted_cnt != total_items)
            @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: end the run if the stream stalls
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/adpcm_ssd_pkg.sv
sv/adpcm_ssd_mac.sv
sv/adpcm_stereo_split_decoder_unit.sv
tb/sv/testbench.sv
